// ===== rtl/core/m4m_pkg.sv =====
// Shared types, constants and the control store of the 4x4 matrix multiplier.
package m4m_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int CNT_W     = $clog2(DIM);
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int ACC_W     = TERM_W + $clog2(DIM) + 1;
    localparam int STEP_W    = 3;

    localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] CMD_MULTIPLY   = 2'd2;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ISSUE = 3'd1;
    localparam logic [STEP_W-1:0] STEP_WAIT0 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_WAIT1 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_CHECK = 3'd5;
    localparam logic [STEP_W-1:0] STEP_LOOP  = 3'd6;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_MUL,
        COND_K_MORE,
        COND_OUT_BUSY,
        COND_ELEM_WRAP
    } cond_t;

    typedef struct packed {
        logic              issue;
        logic              emit;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_word_t;

    typedef struct packed {
        logic [1:0]               command;
        logic [3:0]               element_index;
        logic signed [DATA_W-1:0] element_value;
    } req_beat_t;

    typedef struct packed {
        logic [3:0]               result_index;
        logic signed [DATA_W-1:0] result_value;
        logic                     last;
    } rsp_beat_t;

    typedef struct packed {
        logic             idle;
        logic             issue;
        logic             first;
        logic             emit;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] k;
    } ctrl_t;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1 << FRAC_BITS);

    function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_word_t w;
        w = '{issue: 1'b0, emit: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
        case (step)
            STEP_IDLE:  w = '{1'b0, 1'b0, COND_NO_MUL,    STEP_IDLE};
            STEP_ISSUE: w = '{1'b1, 1'b0, COND_K_MORE,    STEP_ISSUE};
            STEP_WAIT0: w = '{1'b0, 1'b0, COND_NEVER,     STEP_IDLE};
            STEP_WAIT1: w = '{1'b0, 1'b0, COND_NEVER,     STEP_IDLE};
            STEP_EMIT:  w = '{1'b0, 1'b1, COND_OUT_BUSY,  STEP_EMIT};
            STEP_CHECK: w = '{1'b0, 1'b0, COND_ELEM_WRAP, STEP_IDLE};
            STEP_LOOP:  w = '{1'b0, 1'b0, COND_ALWAYS,    STEP_ISSUE};
            default:    w = '{1'b0, 1'b0, COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic is_diag(input logic [CELL_W-1:0] idx);
        logic d;
        d = 1'b0;
        for (int i = 0; i < DIM; i++) begin
            if (idx == CELL_W'(i * (DIM + 1))) begin
                d = 1'b1;
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/m4m_matrix_store.sv =====
// Element store of one matrix, reading as the identity until written.
module m4m_matrix_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [m4m_pkg::CELL_W-1:0]         wr_addr,
    input  logic signed [m4m_pkg::DATA_W-1:0]  wr_data,
    input  logic [m4m_pkg::CELL_W-1:0]         rd_addr,
    output logic signed [m4m_pkg::DATA_W-1:0]  rd_data
);
    import m4m_pkg::*;

    logic signed [DATA_W-1:0] mem [CELLS];
    logic [CELLS-1:0]         valid_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (valid_reg[rd_addr])
        begin
            rd_data_reg <= mem[rd_addr];
        end
        else
        begin
            rd_data_reg <= is_diag(rd_addr) ? ONE : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/m4m_sequencer.sv =====
// Microprogram sequencer: step counter, jump conditions and loop counters.
module m4m_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_command,
    input  logic           out_busy,
    output m4m_pkg::ctrl_t ctrl
);
    import m4m_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    ucode_word_t       word;
    logic              cond_true;
    logic              emit_fire;

    always_comb
    begin
        word = ucode_rom(step_reg);
        case (word.cond)
            COND_NEVER:     cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_NO_MUL:    cond_true = !(req_valid && req_command == CMD_MULTIPLY);
            COND_K_MORE:    cond_true = k_reg != CNT_W'(DIM - 1);
            COND_OUT_BUSY:  cond_true = out_busy;
            COND_ELEM_WRAP: cond_true = row_reg == '0 && col_reg == '0;
            default:        cond_true = 1'b1;
        endcase
        step_next = cond_true ? word.target : step_reg + STEP_W'(1);
        emit_fire = word.emit && !out_busy;

        k_next = k_reg;
        if (word.issue)
        begin
            k_next = (k_reg == CNT_W'(DIM - 1)) ? '0 : k_reg + CNT_W'(1);
        end

        row_next = row_reg;
        col_next = col_reg;
        if (emit_fire)
        begin
            if (col_reg == CNT_W'(DIM - 1))
            begin
                col_next = '0;
                row_next = (row_reg == CNT_W'(DIM - 1)) ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            k_reg    <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            k_reg    <= k_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

    assign ctrl.idle  = step_reg == STEP_IDLE;
    assign ctrl.issue = word.issue;
    assign ctrl.first = k_reg == '0;
    assign ctrl.emit  = emit_fire;
    assign ctrl.row   = row_reg;
    assign ctrl.col   = col_reg;
    assign ctrl.k     = k_reg;

endmodule

// ===== rtl/core/m4m_mac.sv =====
// Multiply, fraction shift, accumulate and saturate datapath.
module m4m_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  m4m_pkg::ctrl_t                    ctrl,
    input  logic signed [m4m_pkg::DATA_W-1:0] left_data,
    input  logic signed [m4m_pkg::DATA_W-1:0] right_data,
    output logic signed [m4m_pkg::DATA_W-1:0] sum_value
);
    import m4m_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W - DATA_W + 1){1'b0}},
                                                   {(DATA_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W - DATA_W + 1){1'b1}},
                                                   {(DATA_W - 1){1'b0}}};

    logic                     rd_vld_reg, rd_first_reg;
    logic                     mul_vld_reg, mul_first_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            mul_vld_reg   <= 1'b0;
            mul_first_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg    <= ctrl.issue;
            rd_first_reg  <= ctrl.first;
            mul_vld_reg   <= rd_vld_reg;
            mul_first_reg <= rd_first_reg;
        end
    end

    assign term = prod_reg[PROD_W-1:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        prod_reg <= left_data * right_data;
        if (mul_vld_reg)
        begin
            acc_reg <= mul_first_reg ? ACC_W'(term) : acc_reg + ACC_W'(term);
        end
    end

    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            sum_value = DATA_W'(SAT_MAX);
        end
        else if (acc_reg < SAT_MIN)
        begin
            sum_value = DATA_W'(SAT_MIN);
        end
        else
        begin
            sum_value = acc_reg[DATA_W-1:0];
        end
    end

endmodule

// ===== rtl/core/matrix4x4_multiply.sv =====
// Top level of the 4x4 signed Q16.16 matrix multiplier.
//
// The block stores a left and a right 4x4 matrix, both the identity after
// reset. A load beat writes one element. A multiply beat produces 16
// result beats of left times right in row-major order, the last one
// marked. One shared 32x32 multiplier runs a microprogram of DIM+5 steps
// per result element: DIM multiply-accumulate issues, two steps for the
// store read and multiplier pipeline to drain, one output step and loop
// checks. The output step waits while the result port is stalled. No new
// beat is taken until a multiply has sent its last result into the output
// register.
module matrix4x4_multiply (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  m4m_pkg::req_beat_t req_beat,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output m4m_pkg::rsp_beat_t rsp_beat
);
    import m4m_pkg::*;

    ctrl_t                    ctrl;
    logic                     accept;
    logic                     idx_ok;
    logic                     left_we, right_we;
    logic [CELL_W-1:0]        wr_addr;
    logic [CELL_W-1:0]        left_addr, right_addr;
    logic signed [DATA_W-1:0] left_data, right_data;
    logic signed [DATA_W-1:0] sum_value;
    logic                     out_busy;
    logic                     rsp_valid_reg;
    rsp_beat_t                rsp_beat_reg;

    assign out_busy  = rsp_valid_reg && rsp_stall;
    assign req_stall = !ctrl.idle;
    assign accept    = req_valid && ctrl.idle;
    assign idx_ok    = int'(req_beat.element_index) < CELLS;
    assign left_we   = accept && idx_ok && req_beat.command == CMD_LOAD_LEFT;
    assign right_we  = accept && idx_ok && req_beat.command == CMD_LOAD_RIGHT;
    assign wr_addr   = CELL_W'(req_beat.element_index);

    assign left_addr  = CELL_W'(int'(ctrl.row) * DIM + int'(ctrl.k));
    assign right_addr = CELL_W'(int'(ctrl.k) * DIM + int'(ctrl.col));

    m4m_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req_beat.command),
        .out_busy    (out_busy),
        .ctrl        (ctrl)
    );

    m4m_matrix_store u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (left_we),
        .wr_addr (wr_addr),
        .wr_data (req_beat.element_value),
        .rd_addr (left_addr),
        .rd_data (left_data)
    );

    m4m_matrix_store u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (right_we),
        .wr_addr (wr_addr),
        .wr_data (req_beat.element_value),
        .rd_addr (right_addr),
        .rd_data (right_data)
    );

    m4m_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .left_data  (left_data),
        .right_data (right_data),
        .sum_value  (sum_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            rsp_beat_reg.result_index <= 4'(int'(ctrl.row) * DIM + int'(ctrl.col));
            rsp_beat_reg.result_value <= sum_value;
            rsp_beat_reg.last         <= ctrl.row == CNT_W'(DIM - 1) &&
                                         ctrl.col == CNT_W'(DIM - 1);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

endmodule
